[design/adlr_pkg.sv]
// ----------------------------------------------------------------------------
// adlr_pkg: shared constants and types for the Adler-32 checksum core
// Lane count, sum widths, modulus and the structs passed between stages.
// ----------------------------------------------------------------------------
package adlr_pkg;

   localparam int LANES      = 8;
   localparam int BYTE_W     = 8;
   localparam int HALF_W     = 16;
   localparam int CSUM_W     = 2 * HALF_W;
   localparam int DATA_W     = 64;
   localparam int COUNT_W    = 4;
   localparam int ADLER_MOD  = 65521;
   localparam int FOLD_MUL   = (1 << HALF_W) - ADLER_MOD;

   localparam int N_W        = $clog2(LANES + 1);
   localparam int IDX_W      = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int WT_W       = BYTE_W + N_W;
   localparam int S_W        = $clog2(LANES * 255 + 1);
   localparam int W_W        = $clog2(255 * LANES * (LANES + 1) / 2 + 1);
   localparam int A_W        = HALF_W + 1;
   localparam int B_W        = HALF_W + N_W + 1;
   localparam int HI_W       = B_W - HALF_W;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_val;
      logic [WT_W-1:0]   weighted;
   } lane_type;

   typedef struct packed {
      logic              start;
      logic [CSUM_W-1:0] seed;
      logic [N_W-1:0]    n;
      logic [S_W-1:0]    s;
      logic [W_W-1:0]    w;
   } merged_type;

endpackage

[design/adlr_lane.sv]
// ----------------------------------------------------------------------------
// adlr_lane: one byte lane
// Masks the byte by the valid count and weights it by the number of
// B updates it feeds within the word.
// ----------------------------------------------------------------------------
module adlr_lane (
   input  logic [adlr_pkg::BYTE_W-1:0] byte_in,
   input  logic [adlr_pkg::N_W-1:0]    n,
   input  logic [adlr_pkg::IDX_W-1:0]  lane_idx,
   output adlr_pkg::lane_type          lane_out
);

   logic                       active;
   logic [adlr_pkg::N_W-1:0]   idx_ext;
   logic [adlr_pkg::N_W-1:0]   weight;
   logic [adlr_pkg::BYTE_W-1:0] masked;

   assign idx_ext = adlr_pkg::N_W'(lane_idx);
   assign active  = idx_ext < n;
   assign weight  = active ? (n - idx_ext) : '0;
   assign masked  = active ? byte_in : '0;

   assign lane_out.byte_val = masked;
   assign lane_out.weighted = adlr_pkg::WT_W'(masked) * adlr_pkg::WT_W'(weight);

endmodule

[design/adlr_merge.sv]
// ----------------------------------------------------------------------------
// adlr_merge: lane merge stage
// Adds the lane bytes and weighted bytes into word totals, registered.
// ----------------------------------------------------------------------------
module adlr_merge (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          start,
   input  logic [adlr_pkg::CSUM_W-1:0]   seed,
   input  logic [adlr_pkg::N_W-1:0]      n,
   input  adlr_pkg::lane_type            lanes [adlr_pkg::LANES],
   output adlr_pkg::merged_type          merged
);

   adlr_pkg::merged_type merged_ff;
   adlr_pkg::merged_type merged_in;

   always_comb begin
      logic [adlr_pkg::S_W-1:0] s_acc;
      logic [adlr_pkg::W_W-1:0] w_acc;
      s_acc = '0;
      w_acc = '0;
      for (int k = 0; k < adlr_pkg::LANES; k++) begin
         s_acc = s_acc + adlr_pkg::S_W'(lanes[k].byte_val);
         w_acc = w_acc + adlr_pkg::W_W'(lanes[k].weighted);
      end
      merged_in.start = start;
      merged_in.seed  = seed;
      merged_in.n     = n;
      merged_in.s     = s_acc;
      merged_in.w     = w_acc;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         merged_ff <= merged_in;
      end
   end

   assign merged = merged_ff;

endmodule

[design/adlr_accum.sv]
// ----------------------------------------------------------------------------
// adlr_accum: running sums
// Applies one word's totals to sums A and B and reduces both mod 65521.
// ----------------------------------------------------------------------------
module adlr_accum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  adlr_pkg::merged_type          merged,
   output logic [adlr_pkg::HALF_W-1:0]   sum_a,
   output logic [adlr_pkg::HALF_W-1:0]   sum_b
);

   localparam logic [adlr_pkg::A_W-1:0] MOD_A = adlr_pkg::A_W'(adlr_pkg::ADLER_MOD);

   logic [adlr_pkg::HALF_W-1:0] sum_a_ff, sum_a_in;
   logic [adlr_pkg::HALF_W-1:0] sum_b_ff, sum_b_in;
   logic [adlr_pkg::HALF_W-1:0] a0, b0;
   logic [adlr_pkg::A_W-1:0]    a_raw, a_red;
   logic [adlr_pkg::B_W-1:0]    b_raw;
   logic [adlr_pkg::HI_W-1:0]   b_hi;
   logic [adlr_pkg::A_W-1:0]    b_fold, b_red;

   // pick seed on a start, else continue from held sums
   assign a0 = merged.start ? merged.seed[adlr_pkg::HALF_W-1:0] : sum_a_ff;
   assign b0 = merged.start ? merged.seed[adlr_pkg::CSUM_W-1:adlr_pkg::HALF_W] : sum_b_ff;

   assign a_raw = adlr_pkg::A_W'(a0) + adlr_pkg::A_W'(merged.s);
   assign a_red = (a_raw >= MOD_A) ? (a_raw - MOD_A) : a_raw;

   // B gains n copies of the old A plus the weighted byte total
   assign b_raw = adlr_pkg::B_W'(b0)
                + adlr_pkg::B_W'(adlr_pkg::B_W'(a0) * adlr_pkg::B_W'(merged.n))
                + adlr_pkg::B_W'(merged.w);
   // 2^16 is congruent to 15: fold the high part back in, then one subtract
   assign b_hi   = b_raw[adlr_pkg::B_W-1:adlr_pkg::HALF_W];
   assign b_fold = adlr_pkg::A_W'(b_raw[adlr_pkg::HALF_W-1:0])
                 + adlr_pkg::A_W'(b_hi) * adlr_pkg::A_W'(adlr_pkg::FOLD_MUL);
   assign b_red  = (b_fold >= MOD_A) ? (b_fold - MOD_A) : b_fold;

   assign sum_a_in = a_red[adlr_pkg::HALF_W-1:0];
   assign sum_b_in = b_red[adlr_pkg::HALF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= adlr_pkg::HALF_W'(1);
         sum_b_ff <= '0;
      end else if (load) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   assign sum_a = sum_a_ff;
   assign sum_b = sum_b_ff;

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      (32'(sum_a_ff) < adlr_pkg::ADLER_MOD) && (32'(sum_b_ff) < adlr_pkg::ADLER_MOD))
      else $error("running sum not reduced");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(sum_a_ff) && $stable(sum_b_ff))
      else $error("sums changed without a load");

   a_fold_bound: assert property (@(posedge clock) disable iff (reset)
      b_fold < (MOD_A << 1))
      else $error("folded B exceeds single-subtract range");

endmodule

[design/adlr32_checksum_core.sv]
// ----------------------------------------------------------------------------
// adler32_checksum_core: streaming Adler-32, eight bytes per transfer
// Byte lanes, a merge adder stage and the running-sum update.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one transfer carries up to eight bytes in
//   req_data, byte 0 in bits 7:0 first, with req_byte_count valid bytes
//   (counts above eight are taken as eight; zero adds nothing). A transfer
//   with req_start_req high loads req_seed (B in 31:16, A in 15:0) first.
//   Response channel (rsp_*): every request transfer yields one response
//   transfer carrying the running checksum B * 65536 + A after that word.
//   Path: lane stage register, merge register, then running sums and rsp_valid.
//   Throughput: one word per cycle, sustained, while rsp_ready stays high.
//   The rate is set by the running-sum update, which folds a whole word
//   into A and B in a single update; lane weighting and merging are
//   pipelined ahead of it.
//   Stalls: when rsp_ready is low the response holds, and the stages in
//   front keep filling; req_ready drops only once every stage is full.
//   Reset: clears all pipeline valid bits and sets A to 1 and B to 0.
// ----------------------------------------------------------------------------
module adler32_checksum_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_start_req,
   input  logic [adlr_pkg::CSUM_W-1:0]       req_seed,
   input  logic [adlr_pkg::DATA_W-1:0]       req_data,
   input  logic [adlr_pkg::COUNT_W-1:0]      req_byte_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [adlr_pkg::CSUM_W-1:0]       rsp_checksum
);

   // stage enables, back to front
   logic acc_en, s2_en, s1_en;

   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   // lane stage registers
   logic                           s1_start_ff;
   logic [adlr_pkg::CSUM_W-1:0]    s1_seed_ff;
   logic [adlr_pkg::N_W-1:0]       s1_n_ff;
   adlr_pkg::lane_type             s1_lane_ff [adlr_pkg::LANES];

   adlr_pkg::lane_type             lane_in [adlr_pkg::LANES];
   logic [adlr_pkg::N_W-1:0]       n_in;
   adlr_pkg::merged_type           merged;
   logic [adlr_pkg::HALF_W-1:0]    sum_a, sum_b;

   // advance the output when empty or taken; each earlier stage when it is
   // empty or the stage behind it advances
   assign acc_en    = !rsp_valid_ff || rsp_ready;
   assign s2_en     = !s2_valid_ff || acc_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   // saturate the byte count to the lane count
   assign n_in = (req_byte_count > adlr_pkg::COUNT_W'(adlr_pkg::LANES))
               ? adlr_pkg::N_W'(adlr_pkg::LANES)
               : req_byte_count[adlr_pkg::N_W-1:0];

   for (genvar k = 0; k < adlr_pkg::LANES; k++) begin : g_lane
      adlr_lane u_lane (
         .byte_in  (req_data[k*adlr_pkg::BYTE_W +: adlr_pkg::BYTE_W]),
         .n        (n_in),
         .lane_idx (adlr_pkg::IDX_W'(k)),
         .lane_out (lane_in[k])
      );
   end

   // capture the request into the lane stage
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_start_ff <= req_start_req;
         s1_seed_ff  <= req_seed;
         s1_n_ff     <= n_in;
         for (int k = 0; k < adlr_pkg::LANES; k++) begin
            s1_lane_ff[k] <= lane_in[k];
         end
      end
   end

   adlr_merge u_merge (
      .clock  (clock),
      .enable (s2_en),
      .start  (s1_start_ff),
      .seed   (s1_seed_ff),
      .n      (s1_n_ff),
      .lanes  (s1_lane_ff),
      .merged (merged)
   );

   // sums update only when a merged word moves into the output stage
   adlr_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .load   (acc_en && s2_valid_ff),
      .merged (merged),
      .sum_a  (sum_a),
      .sum_b  (sum_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (acc_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // the held sums are the response payload; they move only with a load
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = {sum_b, sum_a};

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request did not reach lane stage");

   a_merge_moves: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && acc_en) |=> rsp_valid_ff)
      else $error("merged word lost before output");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken with pipeline full");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming Adler-32 core
// Tracks the running A/B sums of every accepted request word and compares
// each response checksum in order. Starts with directed corner words, then
// random checksum runs, with bursty request traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WORD_TARGET  = 1400;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 400;

   // Running-sum tracker: mirrors A and B and queues the checksum each
   // accepted word must produce.
   class adler_sum_tracker;
      bit [adlr_pkg::HALF_W-1:0] sum_a;
      bit [adlr_pkg::HALF_W-1:0] sum_b;
      bit [adlr_pkg::CSUM_W-1:0] expected_csums[$];
      int                        errors;

      function new();
         sum_a  = 16'd1;
         sum_b  = 16'd0;
         errors = 0;
      endfunction

      function void note_word(bit is_start, bit [adlr_pkg::CSUM_W-1:0] seed,
                              bit [adlr_pkg::DATA_W-1:0] data,
                              bit [adlr_pkg::COUNT_W-1:0] count);
         int unsigned acc_a;
         int unsigned acc_b;
         int unsigned lanes_used;
         int unsigned k;
         lanes_used = (32'(count) > adlr_pkg::LANES) ? adlr_pkg::LANES : 32'(count);
         if (is_start) begin
            acc_a = 32'(seed[adlr_pkg::HALF_W-1:0]);
            acc_b = 32'(seed[adlr_pkg::CSUM_W-1:adlr_pkg::HALF_W]);
         end else begin
            acc_a = 32'(sum_a);
            acc_b = 32'(sum_b);
         end
         for (k = 0; k < lanes_used; k++) begin
            acc_a += 32'(data[8*k +: 8]);
            acc_b += acc_a;
         end
         sum_a = 16'(acc_a % adlr_pkg::ADLER_MOD);
         sum_b = 16'(acc_b % adlr_pkg::ADLER_MOD);
         expected_csums.push_back({sum_b, sum_a});
      endfunction

      function void check_checksum(logic [adlr_pkg::CSUM_W-1:0] got);
         bit [adlr_pkg::CSUM_W-1:0] want;
         if (expected_csums.size() == 0) begin
            errors++;
            $error("checksum: response with nothing pending, actual %08h", got);
            return;
         end
         want = expected_csums.pop_front();
         if (got !== want) begin
            errors++;
            $error("checksum: expected %08h, actual %08h", want, got);
         end
      endfunction

      function int pending_count();
         return expected_csums.size();
      endfunction
   endclass

   typedef enum int {RX_STREAM, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_start_req;
   logic [adlr_pkg::CSUM_W-1:0]   req_seed;
   logic [adlr_pkg::DATA_W-1:0]   req_data;
   logic [adlr_pkg::COUNT_W-1:0]  req_byte_count;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [adlr_pkg::CSUM_W-1:0]   rsp_checksum;

   adler_sum_tracker tracker = new();

   int          words_sent;
   int          burst_left;
   int          cycle_count;
   int          rsp_seen;
   int          hold_left;
   int          hold_mark;
   int          mode_left;
   int          phase_count;
   rx_mode_type rx_mode;
   logic        ready_next;

   adler32_checksum_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_req  (req_start_req),
      .req_seed       (req_seed),
      .req_data       (req_data),
      .req_byte_count (req_byte_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_checksum   (rsp_checksum)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: end the run if the core hangs or drops responses.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** adler32_checksum_core: FAILED **");
         $finish;
      end
   end

   // Offer one word and hold it until the transfer happens. Values read right
   // after the edge are the ones the core sampled at that edge.
   task automatic push_word(input bit is_start, input bit [adlr_pkg::CSUM_W-1:0] seed,
                            input bit [adlr_pkg::DATA_W-1:0] data,
                            input bit [adlr_pkg::COUNT_W-1:0] count);
      int gap;
      req_valid      <= 1'b1;
      req_start_req  <= is_start;
      req_seed       <= seed;
      req_data       <= data;
      req_byte_count <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_word(is_start, seed, data, count);
      words_sent++;
      // Advance the burst; at its end drop valid for a random gap.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(10, 24);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 48);
      end
   endtask

   function automatic bit [adlr_pkg::DATA_W-1:0] random_data();
      case ($urandom_range(0, 15))
         0:       return '0;
         1, 2:    return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic bit [adlr_pkg::CSUM_W-1:0] random_seed();
      case ($urandom_range(0, 7))
         0, 1, 2: return 32'h0000_0001;
         3:       return 32'h0000_0000;
         4:       return {16'($urandom_range(65500, 65535)),
                          16'($urandom_range(65500, 65535))};
         default: return $urandom;
      endcase
   endfunction

   // Receiver: check every response transfer, then pick rsp_ready for the
   // next cycle from the current stall pattern.
   initial begin
      rsp_seen    = 0;
      hold_left   = 0;
      hold_mark   = -1;
      mode_left   = 0;
      phase_count = 0;
      rx_mode     = RX_STREAM;
      rsp_ready   <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            tracker.check_checksum(rsp_checksum);
            rsp_seen++;
         end
         phase_count++;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (rsp_seen != hold_mark && (rsp_seen == 120 || rsp_seen == 900)) begin
            // Hold off long enough for the pipeline to fill and stall requests.
            hold_mark  = rsp_seen;
            hold_left  = HOLD_CYCLES;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (rx_mode)
               RX_STREAM:   ready_next = 1'b1;
               RX_COIN:     ready_next = 1'($urandom_range(0, 1));
               RX_PERIODIC: ready_next = (phase_count % 5) < 3;
               default:     ready_next = ($urandom_range(0, 7) == 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // Stimulus and end of run.
   initial begin
      int msg_len;
      int w;
      bit [adlr_pkg::COUNT_W-1:0] count;
      words_sent     = 0;
      burst_left     = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_start_req  <= 1'b0;
      req_seed       <= '0;
      req_data       <= '0;
      req_byte_count <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words: reset sums, extremes, counts out of range, odd seeds.
      push_word(1'b0, 32'hFFFF_FFFF, 64'h0, 4'd1);              // sums from reset
      push_word(1'b0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      push_word(1'b0, 32'h0, 64'h0, 4'd0);                       // zero count
      push_word(1'b1, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      push_word(1'b1, 32'hFFFF_FFFF, 64'h0, 4'd0);               // both halves above modulus
      push_word(1'b1, 32'hFFF1_FFF1, 64'h0, 4'd0);               // halves equal to modulus
      push_word(1'b1, 32'hFFF0_FFF0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      push_word(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15); // saturated count
      push_word(1'b0, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd9);
      push_word(1'b0, 32'h0, 64'h5555_5555_5555_5555, 4'd8);
      push_word(1'b1, 32'h0000_0000, 64'h0, 4'd1);
      push_word(1'b0, 32'h0, 64'h0807_0605_0403_0201, 4'd3);
      push_word(1'b0, 32'h0, 64'h0807_0605_0403_0201, 4'd7);
      push_word(1'b1, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 4'd8); // restart mid-stream
      push_word(1'b0, 32'h0, 64'hFF00_FF00_FF00_FF00, 4'd12);
      push_word(1'b0, 32'h0, 64'h0000_0000_0000_00FF, 4'd1);

      // Random checksum runs: a start word, full words, a short tail, some noise.
      while (words_sent < WORD_TARGET) begin
         msg_len = $urandom_range(1, 30);
         for (w = 0; w < msg_len; w++) begin
            if (w == msg_len - 1) count = 4'($urandom_range(1, 8));
            else if ($urandom_range(0, 3) != 0) count = 4'd8;
            else count = 4'($urandom_range(0, 15));
            push_word(w == 0, (w == 0) ? random_seed() : $urandom, random_data(), count);
         end
      end

      // Drain: wait out every pending checksum, then a few more cycles.
      req_valid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_count() == 0) begin
         $display("** adler32_checksum_core: PASSED **");
      end else begin
         $display("** adler32_checksum_core: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
design/adlr_pkg.sv
design/adlr_lane.sv
design/adlr_merge.sv
design/adlr_accum.sv
design/adlr32_checksum_core.sv
sim/tb_top.sv
